FILE: src/mowm_pkg.sv
`timescale 1ns / 1ps
package mowm_pkg;
  localparam int MaxItems = 64;
  localparam int ValueBits = 16;
  localparam int IdxBits = $clog2(MaxItems);
  localparam int CntBits = $clog2(MaxItems + 1);

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLEAR, ST_PASS_INIT, ST_PASS_READ, ST_PASS_CMP, ST_PASS_POP,
    ST_ENTER_READ, ST_ENTER, ST_SUFFIX_READ, ST_SUFFIX, ST_OUT_READ, ST_OUT
  } state_t;
endpackage

FILE: src/mowm_ram.sv
`timescale 1ns / 1ps
module mowm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/max_of_window_minimums_unit.sv
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                         | tuser | tlast
// s_axis  | in  | height[15:0]                               | -     | last_item
// m_axis  | out | window_size[6:0], best_minimum[22:7], 0    | overflowed | last_result
// loading takes one item per cycle; a closing item starts the computation
// computation runs as a sequence of states: clear the best table, a forward and a backward
// stack pass with pops, span entry per element, then suffix max per element
// results leave one per cycle while m_tready is high; s_tready is low meanwhile
// rst is synchronous and returns the block to loading with an empty set
module max_of_window_minimums_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // height
  input  logic        s_tlast,   // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // window_size[6:0], best_minimum[22:7], zero pad
  output logic        m_tuser,   // overflowed
  output logic        m_tlast    // last_result
);
  localparam int IB = mowm_pkg::IdxBits;
  localparam int CB = mowm_pkg::CntBits;
  localparam int VB = mowm_pkg::ValueBits;

  mowm_pkg::state_t state, state_next;
  logic [CB-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic          backward, backward_next;
  logic [CB-1:0] step, step_next;
  logic [CB-1:0] sp, sp_next;
  logic [CB-1:0] run, run_next;
  logic [VB-1:0] cur, cur_next;
  logic [VB-1:0] running, running_next;
  logic          ov, ov_next;
  logic [6:0]    osize, osize_next;
  logic [VB-1:0] obest, obest_next;
  logic          olast, olast_next;
  logic          oovf, oovf_next;

  // value store
  logic          v_we;
  logic [IB-1:0] v_wa, v_ra;
  logic [VB-1:0] v_wd, v_rd;
  // stack position and extent
  logic          k_we;
  logic [IB-1:0] k_wa, k_ra;
  logic [2*IB-1:0] k_wd, k_rd;
  // spans
  logic          r_we, l_we;
  logic [IB-1:0] sp_wa, sp_ra;
  logic [IB-1:0] sp_wd, r_rd, l_rd;
  // best per size
  logic          b_we;
  logic [IB-1:0] b_wa, b_ra;
  logic [VB-1:0] b_wd, b_rd;

  mowm_ram #(.Width(VB), .Depth(mowm_pkg::MaxItems)) u_val (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  mowm_ram #(.Width(2*IB), .Depth(mowm_pkg::MaxItems)) u_stk (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
  mowm_ram #(.Width(IB), .Depth(mowm_pkg::MaxItems)) u_rsp (
    .clk, .we(r_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(sp_ra), .rdata(r_rd));
  mowm_ram #(.Width(IB), .Depth(mowm_pkg::MaxItems)) u_lsp (
    .clk, .we(l_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(sp_ra), .rdata(l_rd));
  mowm_ram #(.Width(VB), .Depth(mowm_pkg::MaxItems)) u_best (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

  logic [CB-1:0] pos;
  logic [CB:0]   len;
  logic [IB-1:0] top_pos;
  logic [IB-1:0] top_ext;
  logic          s_acc;
  assign top_pos = k_rd[IB-1:0];
  assign top_ext = k_rd[2*IB-1:IB];
  assign pos = backward ? (count - step - CB'(1)) : step;
  assign len = {2'b0, l_rd} + {2'b0, r_rd};
  assign s_acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mowm_pkg::ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      ov    <= ov_next;
    end
    backward <= backward_next;
    step     <= step_next;
    sp       <= sp_next;
    run      <= run_next;
    cur      <= cur_next;
    running  <= running_next;
    osize    <= osize_next;
    obest    <= obest_next;
    olast    <= olast_next;
    oovf     <= oovf_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next = ovf;
    backward_next = backward;
    step_next = step;
    sp_next = sp;
    run_next = run;
    cur_next = cur;
    running_next = running;
    ov_next = ov;
    osize_next = osize;
    obest_next = obest;
    olast_next = olast;
    oovf_next = oovf;
    s_tready = 1'b0;
    v_we = 1'b0; v_wa = count[IB-1:0]; v_wd = s_tdata[VB-1:0]; v_ra = pos[IB-1:0];
    k_we = 1'b0; k_wa = sp[IB-1:0]; k_wd = {run[IB-1:0], pos[IB-1:0]};
    k_ra = sp[IB-1:0] - IB'(1);
    r_we = 1'b0; l_we = 1'b0; sp_wa = top_pos; sp_wd = run[IB-1:0];
    sp_ra = step[IB-1:0];
    b_we = 1'b0; b_wa = step[IB-1:0]; b_wd = '0; b_ra = step[IB-1:0];
    if (ov && m_tready) ov_next = 1'b0;
    case (state)
      mowm_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        if (s_acc) begin
          if (count < CB'(mowm_pkg::MaxItems)) begin
            v_we = 1'b1;
            count_next = count + CB'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (s_tlast) begin
            step_next = '0;
            state_next = mowm_pkg::ST_CLEAR;
          end
        end
      end
      mowm_pkg::ST_CLEAR: begin
        b_we = 1'b1;
        step_next = step + CB'(1);
        if (step == CB'(mowm_pkg::MaxItems - 1)) begin
          backward_next = 1'b0;
          state_next = mowm_pkg::ST_PASS_INIT;
        end
      end
      mowm_pkg::ST_PASS_INIT: begin
        step_next = '0;
        sp_next = '0;
        state_next = mowm_pkg::ST_PASS_READ;
      end
      mowm_pkg::ST_PASS_READ: begin
        // fetch element value and stack top
        run_next = '0;
        state_next = mowm_pkg::ST_PASS_CMP;
      end
      mowm_pkg::ST_PASS_CMP: begin
        if (step != count) cur_next = v_rd;
        v_ra = top_pos;
        state_next = mowm_pkg::ST_PASS_POP;
      end
      mowm_pkg::ST_PASS_POP: begin
        // v_rd holds stack top value; cur holds current element
        if (sp != '0 && (step == count || cur < v_rd)) begin
          r_we = !backward;
          l_we = backward;
          run_next = run + CB'(top_ext) + CB'(1);
          sp_next = sp - CB'(1);
          k_ra = sp[IB-1:0] - IB'(2);
          state_next = mowm_pkg::ST_PASS_CMP;
        end else if (step != count) begin
          k_we = 1'b1;
          sp_next = sp + CB'(1);
          k_ra = sp[IB-1:0];
          step_next = step + CB'(1);
          state_next = mowm_pkg::ST_PASS_READ;
        end else if (!backward) begin
          backward_next = 1'b1;
          state_next = mowm_pkg::ST_PASS_INIT;
        end else begin
          step_next = '0;
          state_next = mowm_pkg::ST_ENTER_READ;
        end
      end
      mowm_pkg::ST_ENTER_READ: begin
        // spans and value of element step now addressed
        v_ra = step[IB-1:0];
        state_next = mowm_pkg::ST_ENTER;
      end
      mowm_pkg::ST_ENTER: begin
        if (step == count) begin
          step_next = count;
          running_next = '0;
          state_next = mowm_pkg::ST_SUFFIX_READ;
        end else begin
          // read-modify-write of best at len, sequenced via cur
          b_ra = len[IB-1:0];
          cur_next = v_rd;
          run_next = len[CB-1:0];
          state_next = mowm_pkg::ST_SUFFIX;
          backward_next = 1'b0;
          ov_next = ov;
          if (len >= (CB+1)'(mowm_pkg::MaxItems)) begin
            step_next = step + CB'(1);
            state_next = mowm_pkg::ST_ENTER_READ;
          end else begin
            state_next = mowm_pkg::ST_OUT_READ;
            backward_next = 1'b1;
          end
        end
      end
      mowm_pkg::ST_SUFFIX_READ: begin
        b_ra = step[IB-1:0] - IB'(1);
        if (step == '0) begin
          step_next = '0;
          b_ra = '0;
          state_next = mowm_pkg::ST_OUT;
        end else begin
          state_next = mowm_pkg::ST_SUFFIX;
          backward_next = 1'b0;
        end
      end
      mowm_pkg::ST_SUFFIX: begin
        b_wa = step[IB-1:0] - IB'(1);
        b_we = 1'b1;
        b_wd = (b_rd > running) ? b_rd : running;
        running_next = b_wd;
        step_next = step - CB'(1);
        state_next = mowm_pkg::ST_SUFFIX_READ;
      end
      mowm_pkg::ST_OUT_READ: begin
        // span entry write-back: best[len] = max(best[len], value)
        b_wa = run[IB-1:0];
        b_we = cur > b_rd;
        b_wd = cur;
        step_next = step + CB'(1);
        state_next = mowm_pkg::ST_ENTER_READ;
      end
      mowm_pkg::ST_OUT: begin
        if (!ov || m_tready) begin
          if (step == count) begin
            count_next = '0;
            ovf_next = 1'b0;
            state_next = mowm_pkg::ST_LOAD;
          end else begin
            ov_next = 1'b1;
            osize_next = 7'(step) + 7'd1;
            obest_next = b_rd;
            oovf_next = ovf;
            olast_next = (step + CB'(1) == count);
            step_next = step + CB'(1);
            b_ra = step[IB-1:0] + IB'(1);
          end
        end else begin
          b_ra = step[IB-1:0];
        end
      end
      default: state_next = mowm_pkg::ST_LOAD;
    endcase
  end

  assign m_tvalid = ov;
  assign m_tdata = {1'b0, obest, osize};
  assign m_tuser = oovf;
  assign m_tlast = olast;
endmodule

FILE: src/mowm_checker.sv
`timescale 1ns / 1ps
module mowm_protocol_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready during result output");
  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:0] != 7'd0)
    else $error("window size zero");
  a_first_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("input reopened before last result");
endmodule

bind max_of_window_minimums_unit mowm_protocol_checker u_chk (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast);

FILE: test/mowm_checker.sv
`timescale 1ns / 1ps
module mowm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [6:0]  window_size;
    logic [15:0] best_minimum;
    logic        overflowed;
    logic        last_result;
  } window_result_t;

  window_result_t expected_results[$];
  logic [mowm_pkg::ValueBits-1:0] heights[mowm_pkg::MaxItems];
  int set_count;
  logic set_overflow;

  // span of each element: neighbors not smaller, left plus right, not counting itself
  task automatic solve_set();
    int n;
    int lo;
    int hi;
    int span;
    logic [15:0] best[mowm_pkg::MaxItems];
    logic [15:0] running;
    window_result_t r;
    n = set_count;
    for (int i = 0; i < mowm_pkg::MaxItems; i++) best[i] = '0;
    for (int i = 0; i < n; i++) begin
      lo = i;
      hi = i;
      while (lo > 0 && heights[lo-1] >= heights[i]) lo--;
      while (hi < n - 1 && heights[hi+1] >= heights[i]) hi++;
      span = hi - lo;
      if (heights[i] > best[span]) best[span] = heights[i];
    end
    running = '0;
    for (int i = n - 1; i >= 0; i--) begin
      if (best[i] > running) running = best[i];
      best[i] = running;
    end
    for (int i = 0; i < n; i++) begin
      r.window_size = 7'(i + 1);
      r.best_minimum = best[i];
      r.overflowed = set_overflow;
      r.last_result = (i == n - 1);
      expected_results.push_back(r);
    end
    set_count = 0;
    set_overflow = 1'b0;
  endtask

  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    if (rst) begin
      set_count = 0;
      set_overflow = 1'b0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.window_size = m_tdata[6:0];
        got.best_minimum = m_tdata[22:7];
        got.overflowed = m_tuser;
        got.last_result = m_tlast;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_tdata[23] !== 1'b0) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        // blocking updates keep the set bookkeeping ordered within this edge
        if (set_count < mowm_pkg::MaxItems) begin
          heights[set_count] = s_tdata;
          set_count = set_count + 1;
        end else begin
          set_overflow = 1'b1;
        end
        if (s_tlast) solve_set();
      end
      pending <= expected_results.size();
    end
  end
endmodule

FILE: test/tb_max_of_window_minimums_unit.sv
`timescale 1ns / 1ps
module tb_max_of_window_minimums_unit;
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          cycle_count;
  logic        calm_phase;
  logic        hold_off;

  max_of_window_minimums_unit u_dut (.*);

  mowm_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls, one long hold-off, a calm stretch
  initial begin
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (hold_off) m_tready <= 1'b0;
      else if (calm_phase) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(99) >= 12);
    end
  end

  task automatic send_height(input logic [15:0] h, input logic closing);
    while (!calm_phase && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= h;
    s_tlast <= closing;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_set(input int n, input int kind);
    logic [15:0] h;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: h = 16'($urandom);
        1: h = 16'($urandom_range(3));
        2: h = 16'(i * 1000);
        3: h = 16'(65535 - i * 1000);
        default: h = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
      endcase
      send_height(h, i == n - 1);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    calm_phase = 1'b0;
    hold_off = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: single items, extremes, zeros, equal runs, ramps
    send_height(16'h0000, 1'b1);
    send_height(16'hFFFF, 1'b1);
    send_set(3, 2);
    send_set(3, 3);
    send_set(4, 1);
    send_set(4, 4);
    send_height(16'h5555, 1'b0);
    send_height(16'hAAAA, 1'b1);
    drain();
    // overflow: 66 items into a 64-entry store, closing one dropped
    send_set(66, 0);
    // long receiver hold-off while the sender keeps going
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_set(8, 0);
    send_set(6, 1);
    drain();
    calm_phase <= 1'b1;
    send_set(40, 0);
    sent = 40;
    calm_phase <= 1'b0;
    while (sent < 230) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 12);
      send_set(n, $urandom_range(99) < 60 ? 0 : $urandom_range(1, 4));
      sent += n;
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= rst ? 0 : cycle_count + 1;
    if (cycle_count > 500000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule
